// ----- hdl/telnet_byte_parser_unit_assert.svh -----
// assertion helpers for the telnet byte parser
`ifndef TELNET_BYTE_PARSER_UNIT_ASSERT_SVH
`define TELNET_BYTE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TBP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("telnet parser check failed");

// next-cycle implication, checked outside reset
`define TBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("telnet parser check failed");

`endif

// ----- hdl/tbp_pkg.sv -----
`default_nettype none
package tbp_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam int IDX_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_DEL  = 8'd127;
    localparam logic [7:0] B_BS   = 8'd8;
    localparam logic [7:0] B_TAB  = 8'd9;
    localparam logic [7:0] B_LF   = 8'd10;
    localparam logic [7:0] B_CR   = 8'd13;
    localparam logic [7:0] B_SPACE = 8'd32;
    localparam logic [7:0] B_TILDE = 8'd126;

    // operations handed from the parser to the line engine
    localparam logic [1:0] OP_REPLY = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;
    localparam logic [1:0] OP_EOL   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_EOL   = 2'd2;

    typedef struct packed {
        logic [1:0] code;
        logic       wont;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_negotiation(input logic [7:0] b);
        return (b == B_DO) || (b == B_DONT) || (b == B_WILL) || (b == B_WONT);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/tbp_front.sv -----
`default_nettype none
module tbp_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire  [7:0]        i_rx_byte,
    input  tbp_pkg::t_qstat   i_qstat,
    output logic              o_stall,
    output logic              o_push,
    output tbp_pkg::t_op      o_op
);

    localparam logic [2:0] M_NORMAL  = 3'd0;
    localparam logic [2:0] M_IAC     = 3'd1;
    localparam logic [2:0] M_OPTION  = 3'd2;
    localparam logic [2:0] M_SUB     = 3'd3;
    localparam logic [2:0] M_SUB_IAC = 3'd4;

    logic [2:0] r_mode, n_mode;
    logic [7:0] r_pending, n_pending;
    logic       accept;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    always_comb begin
        n_mode       = r_mode;
        n_pending    = r_pending;
        o_push       = 1'b0;
        o_op.code    = tbp_pkg::OP_CHAR;
        o_op.wont    = 1'b0;
        o_op.data    = i_rx_byte;
        if (accept) begin
            case (r_mode)
                M_SUB: begin
                    if (i_rx_byte == tbp_pkg::B_IAC) begin
                        n_mode = M_SUB_IAC;
                    end
                end
                M_SUB_IAC: begin
                    n_mode = (i_rx_byte == tbp_pkg::B_IAC) ? M_SUB : M_NORMAL;
                end
                M_OPTION: begin
                    o_push    = tbp_pkg::is_negotiation(r_pending);
                    o_op.code = tbp_pkg::OP_REPLY;
                    o_op.wont = (r_pending == tbp_pkg::B_DO) || (r_pending == tbp_pkg::B_DONT);
                    n_mode    = M_NORMAL;
                    n_pending = 8'd0;
                end
                M_IAC: begin
                    n_mode = M_NORMAL;
                    if (i_rx_byte == tbp_pkg::B_SB) begin
                        n_mode = M_SUB;
                    end else if (tbp_pkg::is_negotiation(i_rx_byte)) begin
                        n_pending = i_rx_byte;
                        n_mode    = M_OPTION;
                    end
                end
                default: begin
                    n_mode = M_NORMAL;
                    if (i_rx_byte == tbp_pkg::B_IAC) begin
                        n_mode = M_IAC;
                    end else if (i_rx_byte == tbp_pkg::B_LF) begin
                        o_push    = 1'b1;
                        o_op.code = tbp_pkg::OP_EOL;
                    end else if (i_rx_byte == tbp_pkg::B_BS || i_rx_byte == tbp_pkg::B_DEL) begin
                        o_push    = 1'b1;
                        o_op.code = tbp_pkg::OP_ERASE;
                    end else if (i_rx_byte == tbp_pkg::B_TAB ||
                                 (i_rx_byte >= tbp_pkg::B_SPACE &&
                                  i_rx_byte <= tbp_pkg::B_TILDE)) begin
                        o_push    = 1'b1;
                        o_op.code = tbp_pkg::OP_CHAR;
                    end
                    // carriage return and other bytes are dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_NORMAL;
            r_pending <= 8'd0;
        end else begin
            r_mode    <= n_mode;
            r_pending <= n_pending;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tbp_queue.sv -----
`default_nettype none
module tbp_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  tbp_pkg::t_op      i_op,
    input  wire               i_pop,
    output tbp_pkg::t_op      o_op,
    output tbp_pkg::t_qstat   o_qstat
);

    tbp_pkg::t_op                  r_slot [tbp_pkg::QUEUE_DEPTH];
    logic [tbp_pkg::QPTR_W-1:0]    r_wr, r_rd;
    logic [tbp_pkg::QCNT_W-1:0]    r_cnt;
    logic                          do_push, do_pop;

    assign o_qstat.full  = (r_cnt == tbp_pkg::QCNT_W'(tbp_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_op    = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + tbp_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + tbp_pkg::QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + tbp_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - tbp_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tbp_back.sv -----
`default_nettype none
module tbp_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tbp_pkg::t_qstat   i_qstat,
    input  tbp_pkg::t_op      i_op,
    output logic              o_pop,
    input  wire               i_stall,
    output logic              o_valid,
    output logic [1:0]        o_item_kind,
    output logic [7:0]        o_item_byte,
    output logic              o_line_overflowed,
    output logic              o_last_of_run
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REPLY = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHAR  = 3'd3;
    localparam logic [2:0] S_EOL   = 3'd4;

    logic [2:0]                 r_state, n_state;
    logic [1:0]                 r_cnt, n_cnt;
    logic                       r_wont, n_wont;
    logic [7:0]                 r_opt, n_opt;
    logic [tbp_pkg::LEN_W-1:0]  r_len, n_len;
    logic [tbp_pkg::LEN_W-1:0]  r_idx, n_idx;
    logic                       r_ovf, n_ovf;

    logic [7:0]                 r_mem [tbp_pkg::LINE_CAPACITY];
    logic [7:0]                 r_rdata;
    logic                       mem_we, mem_re;

    logic                       r_out_valid;
    logic [1:0]                 r_kind;
    logic [7:0]                 r_byte;
    logic                       r_oovf, r_last;

    logic                       out_free, load;
    logic [1:0]                 ld_kind;
    logic [7:0]                 ld_byte;
    logic                       ld_ovf, ld_last;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_wont  = r_wont;
        n_opt   = r_opt;
        n_len   = r_len;
        n_idx   = r_idx;
        n_ovf   = r_ovf;
        o_pop   = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        load    = 1'b0;
        ld_kind = tbp_pkg::KIND_REPLY;
        ld_byte = tbp_pkg::B_IAC;
        ld_ovf  = 1'b0;
        ld_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    case (i_op.code)
                        tbp_pkg::OP_REPLY: begin
                            n_wont  = i_op.wont;
                            n_opt   = i_op.data;
                            n_cnt   = 2'd0;
                            n_state = S_REPLY;
                        end
                        tbp_pkg::OP_CHAR: begin
                            if (r_len < tbp_pkg::LEN_W'(tbp_pkg::LINE_CAPACITY)) begin
                                mem_we = 1'b1;
                                n_len  = r_len + tbp_pkg::LEN_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        tbp_pkg::OP_ERASE: begin
                            if (r_len != '0) begin
                                n_len = r_len - tbp_pkg::LEN_W'(1);
                            end
                        end
                        default: begin
                            n_idx   = '0;
                            n_state = (r_len == '0) ? S_EOL : S_READ;
                        end
                    endcase
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = tbp_pkg::KIND_REPLY;
                    case (r_cnt)
                        2'd0:    ld_byte = tbp_pkg::B_IAC;
                        2'd1:    ld_byte = r_wont ? tbp_pkg::B_WONT : tbp_pkg::B_DONT;
                        default: ld_byte = r_opt;
                    endcase
                    ld_last = (r_cnt == 2'd2);
                    n_cnt   = r_cnt + 2'd1;
                    if (r_cnt == 2'd2) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_CHAR;
            end
            S_CHAR: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = tbp_pkg::KIND_CHAR;
                    ld_byte = r_rdata;
                    n_idx   = r_idx + tbp_pkg::LEN_W'(1);
                    n_state = (n_idx == r_len) ? S_EOL : S_READ;
                end
            end
            S_EOL: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = tbp_pkg::KIND_EOL;
                    ld_byte = 8'(r_len);
                    ld_ovf  = r_ovf;
                    ld_last = 1'b1;
                    n_len   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // line store, one write or one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_len[tbp_pkg::IDX_W-1:0]] <= i_op.data;
        end
        if (mem_re) begin
            r_rdata <= r_mem[r_idx[tbp_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_wont      <= 1'b0;
            r_len       <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wont  <= n_wont;
            r_len   <= n_len;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_opt <= n_opt;
        if (load) begin
            r_kind <= ld_kind;
            r_byte <= ld_byte;
            r_oovf <= ld_ovf;
            r_last <= ld_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_item_kind       = r_kind;
    assign o_item_byte       = r_byte;
    assign o_line_overflowed = r_oovf;
    assign o_last_of_run     = r_last;

endmodule
`default_nettype wire

// ----- hdl/telnet_byte_parser_unit.sv -----
`default_nettype none
// Telnet receive parser: takes one byte per transaction, drops IAC command and
// subnegotiation sequences, answers DO/DONT with IAC WONT <opt> and WILL/WONT
// with IAC DONT <opt>, and collects tab and printable bytes into a line store of
// tbp_pkg::LINE_CAPACITY bytes. Newline emits the stored characters and then an
// end-of-line item with the length and overflow flag; last_of_run marks the final
// item of each reply or newline. A parser stage decodes bytes combinationally and
// pushes work into a 4-entry queue, so input is taken every cycle until the queue
// fills. Dropped bytes never reach the line engine. The line engine retires a
// character or erase from idle, a negotiation reply as 3 output items, and a
// newline as the stored characters, each costing one registered line store read
// plus one output load, then the end-of-line item. Output stalls hold the engine.
module telnet_byte_parser_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_stall,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [1:0]  o_item_kind,
    output logic [7:0]  o_item_byte,
    output logic        o_line_overflowed,
    output logic        o_last_of_run
);

`include "telnet_byte_parser_unit_assert.svh"

    tbp_pkg::t_qstat q_stat;
    tbp_pkg::t_op    push_op, head_op;
    logic            push, pop;

    tbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_qstat   (q_stat),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_op      (push_op)
    );

    tbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_qstat (q_stat)
    );

    tbp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_qstat           (q_stat),
        .i_op              (head_op),
        .o_pop             (pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_item_kind       (o_item_kind),
        .o_item_byte       (o_item_byte),
        .o_line_overflowed (o_line_overflowed),
        .o_last_of_run     (o_last_of_run)
    );

    `TBP_ASSERT_IMPL(a_queue_sane, q_stat.full, !q_stat.empty)
    `TBP_ASSERT_IMPL(a_eol_last, o_valid && o_item_kind == tbp_pkg::KIND_EOL, o_last_of_run)
    `TBP_ASSERT_IMPL(a_ovf_only_eol, o_valid && o_line_overflowed, o_item_kind == tbp_pkg::KIND_EOL)
    `TBP_ASSERT_NEXT(a_push_gated, push && q_stat.full, q_stat.full)

endmodule
`default_nettype wire
